// ===== design/text_console_scrollback_writer_unit_defines.svh =====
// assertion macros for the text console scrollback writer
// no dependencies; included by the modules that carry assertions
`ifndef TEXT_CONSOLE_SCROLLBACK_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_SCROLLBACK_WRITER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// checked while out of reset
`define TCSW_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define TCSW_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TCSW_ASSERT(label, clk, rst_n, prop, msg)
`define TCSW_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== design/tcsw_pkg.sv =====
// shared types, codes and constants of the text console scrollback writer
// no dependencies
package tcsw_pkg;

    // default geometry
    localparam int LINE_CELLS_DEF    = 80;
    localparam int VISIBLE_LINES_DEF = 24;
    localparam int RING_LINES_DEF    = 128;
    localparam int TAB_STEP_DEF      = 8;

    // beat field widths
    localparam int MODE_W   = 3;
    localparam int CHAR_W   = 8;
    localparam int COLOR_W  = 4;
    localparam int DIR_W    = 2;
    localparam int IDX_W    = 11;
    localparam int CELL_W   = 16;
    localparam int CURSOR_W = 11;
    localparam int TOP_W_O  = 7;
    localparam int ROOM_W   = 7;

    typedef logic [CELL_W-1:0] t_cell;

    localparam t_cell BLANK_CELL = 16'h0F00;

    // operation codes
    localparam logic [MODE_W-1:0] MODE_WRITE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BACK  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FWD   = 3'd2;
    localparam logic [MODE_W-1:0] MODE_MOVE  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

    // control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'd32;

    // cursor move directions
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    function automatic t_cell make_cell(input logic [CHAR_W-1:0] ch,
                                        input logic [COLOR_W-1:0] fg,
                                        input logic [COLOR_W-1:0] bg);
        return {bg, fg, ch};
    endfunction

endpackage

// ===== design/text_console_scrollback_writer_unit.sv =====
// text console with scrollback: sequencer, cursor and scroll state around the cell ring
// depends on tcsw_pkg, tcsw_cell_ram and text_console_scrollback_writer_unit_defines.svh

// The block keeps RING_LINES lines of LINE_CELLS cells (bg, fg, char) in one single-port
// memory with a registered read, and shows a window of VISIBLE_LINES lines from top_line
// on. Every input beat yields exactly one result beat. After reset a clearing pass writes
// the blank cell 0x0F00 into every entry, one per cycle, so inputs are stalled until that
// pass is through; config writes are taken throughout.
// Items are handled one at a time by a sequencer that owns the memory port; a new input
// beat is taken only once the last result is in the output register. Scroll and cursor
// moves go straight to the result. A printable character or backspace goes through
// scroll check, ring-line wrap, cell write and result. Newline and tab expand into n
// space writes (n up to LINE_CELLS or TAB_STEP), each with its own scroll check. Whenever
// the cursor hits the last visible cell the window scrolls and the new bottom line is
// blanked. A cell read splits the index into line and column by a reciprocal multiply,
// then does the ring-line wrap and the memory read. The ring-line wrap subtracts
// RING_LINES again each time it passes the end of the ring.
// A finished result sits in an output register while the next beat is accepted.
`include "text_console_scrollback_writer_unit_defines.svh"

module text_console_scrollback_writer_unit import tcsw_pkg::*; #(
    parameter int LINE_CELLS    = LINE_CELLS_DEF,
    parameter int VISIBLE_LINES = VISIBLE_LINES_DEF,
    parameter int RING_LINES    = RING_LINES_DEF,
    parameter int TAB_STEP      = TAB_STEP_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input beats
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic [MODE_W-1:0]   i_mode,
    input  logic [CHAR_W-1:0]   i_char_code,
    input  logic [COLOR_W-1:0]  i_fg_color,
    input  logic [COLOR_W-1:0]  i_bg_color,
    input  logic [DIR_W-1:0]    i_direction,
    input  logic [IDX_W-1:0]    i_read_index,
    // result beats
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output logic [CELL_W-1:0]   o_cell_value,
    output logic [CURSOR_W-1:0] o_cursor_pos,
    output logic [TOP_W_O-1:0]  o_top_line_index,
    output logic [ROOM_W-1:0]   o_back_room,
    output logic [ROOM_W-1:0]   o_forward_room,
    // refresh_disabled register
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_data
);

    // geometry
    localparam int VIS_CELLS    = LINE_CELLS * VISIBLE_LINES;
    localparam int RING_CELLS   = LINE_CELLS * RING_LINES;
    localparam int SCROLL_LIMIT = (RING_LINES > VISIBLE_LINES) ? RING_LINES - VISIBLE_LINES : 0;

    localparam int COL_W  = $clog2(LINE_CELLS);
    localparam int LINE_W = $clog2(VISIBLE_LINES);
    localparam int TOP_W  = $clog2(RING_LINES);
    localparam int SUM_W  = $clog2(RING_LINES + VISIBLE_LINES);
    localparam int CNT_W  = (SCROLL_LIMIT > 0) ? $clog2(SCROLL_LIMIT + 1) : 1;
    localparam int PH_W   = $clog2(TAB_STEP);
    localparam int ADDR_W = $clog2(RING_CELLS);
    localparam int CUR_W  = $clog2(VIS_CELLS);
    localparam int RUN_MAX = (LINE_CELLS > TAB_STEP) ? LINE_CELLS : TAB_STEP;
    localparam int RUN_W  = $clog2(RUN_MAX + 1);
    localparam int CMP_W  = ((CUR_W > IDX_W) ? CUR_W : IDX_W) + 1;

    // read index split: q0 = (idx * RECIP_MUL) >> RECIP_SHIFT is the line or one below
    localparam int RECIP_SHIFT = IDX_W + COL_W + 1;
    localparam int RECIP_MUL   = (2 ** RECIP_SHIFT) / LINE_CELLS;
    localparam int PROD_W      = IDX_W + RECIP_SHIFT;

    localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(LINE_CELLS - 1);
    localparam logic [LINE_W-1:0] LAST_LINE = LINE_W'(VISIBLE_LINES - 1);
    localparam logic [TOP_W-1:0]  LAST_TOP  = TOP_W'(RING_LINES - 1);
    localparam logic [CNT_W-1:0]  CNT_LIMIT = CNT_W'(SCROLL_LIMIT);

    // tab phase (flat cursor mod TAB_STEP) offsets for each kind of cursor jump
    localparam int K_LC      = LINE_CELLS % TAB_STEP;
    localparam int K_VIS_LC  = (VIS_CELLS - LINE_CELLS) % TAB_STEP;
    localparam int K_LC1     = (LINE_CELLS - 1) % TAB_STEP;
    localparam logic [PH_W-1:0] PH_INC        = PH_W'(1);
    localparam logic [PH_W-1:0] PH_DEC        = PH_W'(TAB_STEP - 1);
    localparam logic [PH_W-1:0] PH_ADD_LC     = PH_W'(K_LC);
    localparam logic [PH_W-1:0] PH_SUB_LC     = PH_W'((TAB_STEP - K_LC) % TAB_STEP);
    localparam logic [PH_W-1:0] PH_ADD_VIS_LC = PH_W'(K_VIS_LC);
    localparam logic [PH_W-1:0] PH_SUB_VIS_LC = PH_W'((TAB_STEP - K_VIS_LC) % TAB_STEP);
    localparam logic [PH_W-1:0] PH_ADD_LC1    = PH_W'(K_LC1);
    localparam logic [PH_W-1:0] PH_SUB_LC1    = PH_W'((TAB_STEP - K_LC1) % TAB_STEP);

    // sequencer states
    localparam logic [3:0] S_CLEAR = 4'd0;   // reset clearing pass over the ring
    localparam logic [3:0] S_IDLE  = 4'd1;   // waiting for an input beat
    localparam logic [3:0] S_SCHK  = 4'd2;   // scroll check, then dispatch
    localparam logic [3:0] S_RED   = 4'd3;   // wrap ring line into the ring
    localparam logic [3:0] S_BLANK = 4'd4;   // blank the new bottom line
    localparam logic [3:0] S_WRITE = 4'd5;   // write one cell at the cursor
    localparam logic [3:0] S_DIVQ  = 4'd6;   // read index: estimate line
    localparam logic [3:0] S_DIVC  = 4'd7;   // read index: correct line, get column
    localparam logic [3:0] S_RDA   = 4'd8;   // issue cell read
    localparam logic [3:0] S_RDD   = 4'd9;   // capture cell read data
    localparam logic [3:0] S_DONE  = 4'd10;  // hand result to the output register

    // scroll check context
    localparam logic CTX_FIRST = 1'b0;       // check before the character is handled
    localparam logic CTX_PUT   = 1'b1;       // check before one space of a newline or tab

    // what follows a cell write
    localparam logic [1:0] WK_PRINT = 2'd0;  // printable: advance cursor, done
    localparam logic [1:0] WK_PUT   = 2'd1;  // expansion space: advance, count down
    localparam logic [1:0] WK_BS    = 2'd2;  // backspace: done

    // sequencer and cursor state
    logic [3:0]          r_state, n_state;
    logic [3:0]          r_red_next, n_red_next;
    logic                r_ctx, n_ctx;
    logic [1:0]          r_wkind, n_wkind;
    logic [ADDR_W-1:0]   r_sweep, n_sweep;
    logic [LINE_W-1:0]   r_line, n_line;
    logic [COL_W-1:0]    r_col, n_col;
    logic [PH_W-1:0]     r_phase, n_phase;
    logic [TOP_W-1:0]    r_top, n_top;
    logic [CNT_W-1:0]    r_back, n_back;
    logic [CNT_W-1:0]    r_fwd, n_fwd;
    logic                r_cfg;
    logic                r_out_valid, n_out_valid;

    // per-item work registers
    logic [CHAR_W-1:0]   r_ch, n_ch;
    logic [COLOR_W-1:0]  r_fg, n_fg;
    logic [COLOR_W-1:0]  r_bg, n_bg;
    logic [IDX_W-1:0]    r_idx, n_idx;
    logic [RUN_W-1:0]    r_run, n_run;
    logic [SUM_W-1:0]    r_rsum, n_rsum;
    logic [TOP_W-1:0]    r_rline, n_rline;
    logic [COL_W-1:0]    r_rcol, n_rcol;
    logic [LINE_W-1:0]   r_q, n_q;
    t_cell               r_wval, n_wval;
    t_cell               r_cell, n_cell;

    // result payload
    t_cell               r_out_cell;
    logic [CURSOR_W-1:0] r_out_cursor;
    logic [TOP_W_O-1:0]  r_out_top;
    logic [ROOM_W-1:0]   r_out_back;
    logic [ROOM_W-1:0]   r_out_fwd;

    // memory port
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_addr;
    t_cell               ram_wdata;
    t_cell               ram_rdata;

    logic                in_acc;
    logic                out_load;
    logic [CUR_W-1:0]    cursor_flat;
    logic [COL_W-1:0]    acc_col;
    logic [ADDR_W-1:0]   line_base;
    logic [PROD_W-1:0]   recip_prod;
    logic [IDX_W-1:0]    div_rem;

    // add a jump offset to the tab phase, wrapping at TAB_STEP
    function automatic logic [PH_W-1:0] ph_add(input logic [PH_W-1:0] ph,
                                               input logic [PH_W-1:0] k);
        logic [PH_W:0] s;
        s = {1'b0, ph} + {1'b0, k};
        if (s >= (PH_W+1)'(TAB_STEP)) begin
            s = s - (PH_W+1)'(TAB_STEP);
        end
        return s[PH_W-1:0];
    endfunction

    function automatic logic [TOP_W-1:0] top_inc(input logic [TOP_W-1:0] t);
        return (t == LAST_TOP) ? '0 : t + 1'b1;
    endfunction

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    assign cursor_flat = CUR_W'(r_line) * CUR_W'(LINE_CELLS) + CUR_W'(r_col);
    assign recip_prod  = PROD_W'(r_idx) * PROD_W'(RECIP_MUL);
    assign div_rem     = r_idx - IDX_W'(r_q) * IDX_W'(LINE_CELLS);

    // memory address: ring line times line width plus column, or the raw sweep on clear
    assign acc_col   = (r_state == S_BLANK) ? r_sweep[COL_W-1:0] : r_rcol;
    assign line_base = ADDR_W'(r_rline) * ADDR_W'(LINE_CELLS);

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = line_base + ADDR_W'(acc_col);
        ram_wdata = BLANK_CELL;
        case (r_state)
            S_CLEAR: begin
                ram_we   = 1'b1;
                ram_addr = r_sweep;
            end
            S_BLANK: begin
                ram_we = 1'b1;
            end
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_wdata = r_wval;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_red_next  = r_red_next;
        n_ctx       = r_ctx;
        n_wkind     = r_wkind;
        n_sweep     = r_sweep;
        n_line      = r_line;
        n_col       = r_col;
        n_phase     = r_phase;
        n_top       = r_top;
        n_back      = r_back;
        n_fwd       = r_fwd;
        n_ch        = r_ch;
        n_fg        = r_fg;
        n_bg        = r_bg;
        n_idx       = r_idx;
        n_run       = r_run;
        n_rsum      = r_rsum;
        n_rline     = r_rline;
        n_rcol      = r_rcol;
        n_q         = r_q;
        n_wval      = r_wval;
        n_cell      = r_cell;
        n_out_valid = r_out_valid && i_out_stall;
        out_load    = 1'b0;

        case (r_state)
            S_CLEAR: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == ADDR_W'(RING_CELLS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_acc) begin
                    n_ch    = i_char_code;
                    n_fg    = i_fg_color;
                    n_bg    = i_bg_color;
                    n_idx   = i_read_index;
                    n_cell  = '0;
                    n_state = S_DONE;
                    case (i_mode)
                        MODE_WRITE: begin
                            n_ctx   = CTX_FIRST;
                            n_state = S_SCHK;
                        end
                        MODE_BACK: begin
                            if (r_back != '0) begin
                                n_back = r_back - 1'b1;
                                n_top  = (r_top == '0) ? LAST_TOP : r_top - 1'b1;
                                if (r_fwd < CNT_LIMIT) begin
                                    n_fwd = r_fwd + 1'b1;
                                end
                            end
                        end
                        MODE_FWD: begin
                            if (r_fwd != '0) begin
                                n_fwd = r_fwd - 1'b1;
                                n_top = top_inc(r_top);
                                if (r_back < CNT_LIMIT) begin
                                    n_back = r_back + 1'b1;
                                end
                            end
                        end
                        MODE_MOVE: begin
                            if (!r_cfg) begin
                                case (i_direction)
                                    DIR_UP: begin
                                        if (r_line == '0) begin
                                            n_line  = LAST_LINE;
                                            n_phase = ph_add(r_phase, PH_ADD_VIS_LC);
                                        end else begin
                                            n_line  = r_line - 1'b1;
                                            n_phase = ph_add(r_phase, PH_SUB_LC);
                                        end
                                    end
                                    DIR_DOWN: begin
                                        if (r_line == LAST_LINE) begin
                                            n_line  = '0;
                                            n_phase = ph_add(r_phase, PH_SUB_VIS_LC);
                                        end else begin
                                            n_line  = r_line + 1'b1;
                                            n_phase = ph_add(r_phase, PH_ADD_LC);
                                        end
                                    end
                                    DIR_LEFT: begin
                                        if (r_col == '0) begin
                                            n_col   = LAST_COL;
                                            n_phase = ph_add(r_phase, PH_ADD_LC1);
                                        end else begin
                                            n_col   = r_col - 1'b1;
                                            n_phase = ph_add(r_phase, PH_DEC);
                                        end
                                    end
                                    default: begin
                                        if (r_col == LAST_COL) begin
                                            n_col   = '0;
                                            n_phase = ph_add(r_phase, PH_SUB_LC1);
                                        end else begin
                                            n_col   = r_col + 1'b1;
                                            n_phase = ph_add(r_phase, PH_INC);
                                        end
                                    end
                                endcase
                            end
                        end
                        MODE_READ: begin
                            if (CMP_W'(i_read_index) < CMP_W'(VIS_CELLS)) begin
                                n_state = S_DIVQ;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_SCHK: begin
                if (r_line == LAST_LINE && r_col == LAST_COL) begin
                    // cursor on the last cell: scroll one line, blank the new bottom line
                    if (r_back < CNT_LIMIT) begin
                        n_back = r_back + 1'b1;
                    end
                    n_top      = top_inc(r_top);
                    n_line     = r_line - 1'b1;
                    n_phase    = ph_add(r_phase, PH_SUB_LC);
                    n_rsum     = SUM_W'(top_inc(r_top)) + SUM_W'(LAST_LINE);
                    n_red_next = S_BLANK;
                    n_state    = S_RED;
                end else if (r_ctx == CTX_PUT) begin
                    n_wval     = make_cell(CH_SPACE, r_fg, r_bg);
                    n_wkind    = WK_PUT;
                    n_rcol     = r_col;
                    n_rsum     = SUM_W'(r_top) + SUM_W'(r_line);
                    n_red_next = S_WRITE;
                    n_state    = S_RED;
                end else begin
                    case (r_ch)
                        CH_NEWLINE: begin
                            n_run = RUN_W'(LINE_CELLS) - RUN_W'(r_col);
                            n_ctx = CTX_PUT;
                        end
                        CH_TAB: begin
                            n_run = RUN_W'(TAB_STEP) - RUN_W'(r_phase);
                            n_ctx = CTX_PUT;
                        end
                        CH_BACKSPACE: begin
                            if (r_line == '0 && r_col == '0) begin
                                n_state = S_DONE;
                            end else begin
                                if (r_col == '0) begin
                                    n_col  = LAST_COL;
                                    n_line = r_line - 1'b1;
                                end else begin
                                    n_col  = r_col - 1'b1;
                                end
                                n_phase    = ph_add(r_phase, PH_DEC);
                                n_wval     = make_cell(CH_SPACE, r_fg, r_bg);
                                n_wkind    = WK_BS;
                                n_rcol     = n_col;
                                n_rsum     = SUM_W'(r_top) + SUM_W'(n_line);
                                n_red_next = S_WRITE;
                                n_state    = S_RED;
                            end
                        end
                        default: begin
                            n_wval     = make_cell(r_ch, r_fg, r_bg);
                            n_wkind    = WK_PRINT;
                            n_rcol     = r_col;
                            n_rsum     = SUM_W'(r_top) + SUM_W'(r_line);
                            n_red_next = S_WRITE;
                            n_state    = S_RED;
                        end
                    endcase
                end
            end

            S_RED: begin
                if (r_rsum >= SUM_W'(RING_LINES)) begin
                    n_rsum = r_rsum - SUM_W'(RING_LINES);
                end else begin
                    n_rline = r_rsum[TOP_W-1:0];
                    n_sweep = '0;
                    n_state = r_red_next;
                end
            end

            S_BLANK: begin
                n_sweep = r_sweep + 1'b1;
                if (r_sweep == ADDR_W'(LINE_CELLS - 1)) begin
                    n_state = S_SCHK;
                end
            end

            S_WRITE: begin
                n_state = S_DONE;
                if (r_wkind == WK_PRINT || r_wkind == WK_PUT) begin
                    if (r_col == LAST_COL) begin
                        n_col  = '0;
                        n_line = r_line + 1'b1;
                    end else begin
                        n_col  = r_col + 1'b1;
                    end
                    n_phase = ph_add(r_phase, PH_INC);
                end
                if (r_wkind == WK_PUT) begin
                    n_run = r_run - 1'b1;
                    if (r_run != RUN_W'(1)) begin
                        n_state = S_SCHK;
                    end
                end
            end

            S_DIVQ: begin
                n_q     = recip_prod[RECIP_SHIFT +: LINE_W];
                n_state = S_DIVC;
            end

            S_DIVC: begin
                if (div_rem >= IDX_W'(LINE_CELLS)) begin
                    n_rcol = COL_W'(div_rem - IDX_W'(LINE_CELLS));
                    n_rsum = SUM_W'(r_top) + SUM_W'(r_q) + SUM_W'(1);
                end else begin
                    n_rcol = COL_W'(div_rem);
                    n_rsum = SUM_W'(r_top) + SUM_W'(r_q);
                end
                n_red_next = S_RDA;
                n_state    = S_RED;
            end

            S_RDA: begin
                n_state = S_RDD;
            end

            S_RDD: begin
                n_cell  = ram_rdata;
                n_state = S_DONE;
            end

            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_red_next  <= S_IDLE;
            r_ctx       <= CTX_FIRST;
            r_wkind     <= WK_PRINT;
            r_sweep     <= '0;
            r_line      <= '0;
            r_col       <= '0;
            r_phase     <= '0;
            r_top       <= '0;
            r_back      <= '0;
            r_fwd       <= '0;
            r_run       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_red_next  <= n_red_next;
            r_ctx       <= n_ctx;
            r_wkind     <= n_wkind;
            r_sweep     <= n_sweep;
            r_line      <= n_line;
            r_col       <= n_col;
            r_phase     <= n_phase;
            r_top       <= n_top;
            r_back      <= n_back;
            r_fwd       <= n_fwd;
            r_run       <= n_run;
            r_out_valid <= n_out_valid;
        end
    end

    // config register, to be written by the user only between items; the block does not enforce it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg <= i_cfg_data;
        end
    end

    // item work registers
    always_ff @(posedge i_clk) begin
        r_ch    <= n_ch;
        r_fg    <= n_fg;
        r_bg    <= n_bg;
        r_idx   <= n_idx;
        r_rsum  <= n_rsum;
        r_rline <= n_rline;
        r_rcol  <= n_rcol;
        r_q     <= n_q;
        r_wval  <= n_wval;
        r_cell  <= n_cell;
    end

    // result beat payload, held while the far side stalls
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_cell   <= r_cell;
            r_out_cursor <= CURSOR_W'(cursor_flat);
            r_out_top    <= TOP_W_O'(r_top);
            r_out_back   <= ROOM_W'(r_back);
            r_out_fwd    <= ROOM_W'(r_fwd);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_cell_value     = r_out_cell;
    assign o_cursor_pos     = r_out_cursor;
    assign o_top_line_index = r_out_top;
    assign o_back_room      = r_out_back;
    assign o_forward_room   = r_out_fwd;

    tcsw_cell_ram #(
        .DEPTH (RING_CELLS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // reset always restarts the clearing pass
    `TCSW_ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> (r_state == S_CLEAR), "reset did not start the clearing pass")
    // scroll room counters stay within the limit
    `TCSW_ASSERT(a_room_limit, i_clk, i_rst_n, (r_back <= CNT_LIMIT && r_fwd <= CNT_LIMIT), "scroll room past limit")
    // a successful scroll back always leaves room to scroll forward
    `TCSW_ASSERT(a_back_gives_fwd, i_clk, i_rst_n, (in_acc && i_mode == MODE_BACK && r_back != '0) |=> (r_fwd != '0), "scroll back left no forward room")
    // the space loop of newline and tab never runs with nothing left to write
    `TCSW_ASSERT(a_run_nonzero, i_clk, i_rst_n, (r_state == S_SCHK && r_ctx == CTX_PUT) |-> (r_run != '0), "space run empty")
    // cursor column and tab phase stay in range
    `TCSW_ASSERT(a_cursor_range, i_clk, i_rst_n, (r_col <= LAST_COL && r_line <= LAST_LINE && 32'(r_phase) < TAB_STEP), "cursor out of range")

endmodule

// ===== design/tcsw_cell_ram.sv =====
// single-port cell memory of the console ring, registered read data
// depends on tcsw_pkg
module tcsw_cell_ram import tcsw_pkg::*; #(
    parameter int DEPTH = LINE_CELLS_DEF * RING_LINES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  t_cell                    i_wdata,
    output t_cell                    o_rdata
);

    t_cell r_mem [DEPTH];
    t_cell r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule
